// ===== rtl/lpf_pkg.sv =====
package lpf_pkg;

  localparam int VALUE_WIDTH = 48;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  // stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VALUE_WIDTH + 2 + 7) / 8) * 8;

  localparam logic [VALUE_WIDTH-1:0] FACTOR_TWO = VALUE_WIDTH'(2);
  localparam logic [VALUE_WIDTH-1:0] DIV_FIRST  = VALUE_WIDTH'(3);
  localparam logic [VALUE_WIDTH-1:0] DIV_STEP   = VALUE_WIDTH'(2);

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [VALUE_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/lpf_divider.sv =====
module lpf_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpf_pkg::div_req_t req_i,
  output lpf_pkg::div_rsp_t rsp_o
);
  import lpf_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] dvs_q, dvs_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;

  // restoring step: shift one dividend bit into the partial remainder
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_WIDTH);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
      rem_d = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== rtl/largest_prime_factor.sv =====
// Largest prime factor by trial division. Each input word carries one unsigned
// value; each output word returns its largest prime factor with a prime flag
// (the value itself is prime) and an invalid flag (value 0 or 1, factor 0).
// Factors of two are shifted out first, one bit per cycle. Odd trial divisors
// 3, 5, 7, ... then go through one shared restoring divider that produces one
// quotient bit per cycle. A divisor is retried while it still divides, and the
// search stops once a newly tried divisor exceeds the quotient. The run time
// grows with the last odd divisor tried (just above the larger of the second
// largest prime factor, counted with repetition, and the square root of the
// largest one, at most about 2^(VALUE_WIDTH/2)) and with the number of odd
// factors divided out; a large prime input is the worst case.
// The block takes one word at a time: s_axis_tready is high only while the
// sequencer is idle. A finished result waits in the output register, so a new
// word is taken while the previous result is still pending.
module largest_prime_factor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: [VALUE_WIDTH-1:0] value, zero padded to bytes
  input  logic [lpf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: [VALUE_WIDTH-1:0] largest_factor, [VALUE_WIDTH] value_is_prime,
  //        [VALUE_WIDTH+1] invalid_input, zero padded to bytes
  output logic [lpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import lpf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRIP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] val_q;      // original value, for the prime check
  logic [VALUE_WIDTH-1:0] rest_q;     // remaining cofactor
  logic [VALUE_WIDTH-1:0] best_q;     // largest factor found so far
  logic [VALUE_WIDTH-1:0] dvs_q;      // current trial divisor
  logic                   inner_q;    // repeat division with the same divisor
  logic                   invalid_q;
  logic                   m_valid_q;
  logic [VALUE_WIDTH-1:0] out_factor_q;
  logic                   out_prime_q;
  logic                   out_invalid_q;

  logic [VALUE_WIDTH-1:0] in_value;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];

  assign div_req.start    = (state_q == ST_DIV_START);
  assign div_req.dividend = rest_q;
  assign div_req.divisor  = dvs_q;

  lpf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      val_q         <= '0;
      rest_q        <= '0;
      best_q        <= '0;
      dvs_q         <= '0;
      inner_q       <= 1'b0;
      invalid_q     <= 1'b0;
      m_valid_q     <= 1'b0;
      out_factor_q  <= '0;
      out_prime_q   <= 1'b0;
      out_invalid_q <= 1'b0;
    end else begin
      // drop the result once the sink takes it, unless a new one replaces it
      if (m_valid_q && m_axis_tready && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            val_q  <= in_value;
            rest_q <= in_value;
            best_q <= '0;
            if (in_value[VALUE_WIDTH-1:1] == '0) begin
              // zero and one have no prime factor
              invalid_q <= 1'b1;
              state_q   <= ST_FINISH;
            end else begin
              invalid_q <= 1'b0;
              state_q   <= ST_STRIP;
            end
          end
        end
        ST_STRIP: begin
          // shift out factors of two; rest is nonzero here
          if (!rest_q[0]) begin
            rest_q <= {1'b0, rest_q[VALUE_WIDTH-1:1]};
            best_q <= FACTOR_TWO;
          end else begin
            dvs_q   <= DIV_FIRST;
            inner_q <= 1'b0;
            state_q <= ST_DIV_START;
          end
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (!inner_q && (dvs_q > div_rsp.quotient)) begin
              // divisor passed the square root: any cofactor left is prime
              if (rest_q[VALUE_WIDTH-1:1] != '0) begin
                best_q <= rest_q;
              end
              state_q <= ST_FINISH;
            end else if (div_rsp.remainder == '0) begin
              rest_q  <= div_rsp.quotient;
              best_q  <= dvs_q;
              inner_q <= 1'b1;
              state_q <= ST_DIV_START;
            end else begin
              dvs_q   <= dvs_q + DIV_STEP;
              inner_q <= 1'b0;
              state_q <= ST_DIV_START;
            end
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready) begin
            out_factor_q  <= best_q;
            out_prime_q   <= !invalid_q && (best_q == val_q);
            out_invalid_q <= invalid_q;
            m_valid_q     <= 1'b1;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_invalid_q, out_prime_q, out_factor_q});

  // the shared divider runs only while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_DIV_WAIT))
    else $error("divider busy outside the divide wait state");

  // a divide result arrives only when the sequencer expects it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_WAIT))
    else $error("divider done pulse outside the divide wait state");

  // an accepted word keeps the input closed for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after accepting a word");

  // an invalid result carries factor zero and no prime flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_invalid_q) |-> ((out_factor_q == '0) && !out_prime_q))
    else $error("invalid result with a nonzero factor or prime flag");

endmodule
